// File: rtl/core/fohash_pkg.sv
// shared constants, codes and types of the open-addressing hash table
package fohash_pkg;

	localparam int TABLE_BITS = 10;
	localparam int TABLE_SIZE = 1 << TABLE_BITS;
	localparam int KEY_W      = 32;
	localparam int VALUE_W    = 32;
	localparam int LIMIT_W    = 10;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(512);

	localparam logic [31:0] HASH_C1     = 32'h85EB_CA6B;
	localparam logic [31:0] HASH_C2     = 32'hC2B2_AE35;
	localparam logic [31:0] HASH_MASK31 = 32'h7FFF_FFFF;

	localparam logic FUNC_SET = 1'b0;
	localparam logic FUNC_GET = 1'b1;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef logic [TABLE_BITS-1:0] slot_idx_t;

	typedef struct packed {
		logic                      func;
		logic [KEY_W-1:0]          key;
		logic signed [VALUE_W-1:0] new_value;
		logic signed [VALUE_W-1:0] fallback;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic                      key_present;
		logic                      status;
	} rsp_t;

	typedef struct packed {
		logic               live;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} slot_t;

endpackage

// File: rtl/core/fohash_if.sv
// request and response channel interfaces
interface fohash_req_if import fohash_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [KEY_W-1:0]          key;
	logic signed [VALUE_W-1:0] new_value;
	logic signed [VALUE_W-1:0] fallback;

	modport source (output valid, func, key, new_value, fallback, input ready);
	modport sink (input valid, func, key, new_value, fallback, output ready);
endinterface

interface fohash_rsp_if import fohash_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] read_value;
	logic                      key_present;
	logic                      status;

	modport source (output valid, read_value, key_present, status, input ready);
	modport sink (input valid, read_value, key_present, status, output ready);
endinterface

// File: rtl/core/fohash_hash.sv
// two-stage pipelined 32-bit finalizer hash giving the home slot
module fohash_hash import fohash_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [KEY_W-1:0] key,
	output logic             home_valid,
	output slot_idx_t        home
);

	logic        v_s1, v_s2;
	logic [31:0] m_s1, m_s2;
	logic [31:0] mix1, mix2, mix3;

	assign mix1 = key ^ (key >> 16);
	assign mix2 = m_s1 ^ (m_s1 >> 13);
	assign mix3 = (m_s2 ^ (m_s2 >> 16)) & HASH_MASK31;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		m_s1 <= 32'(mix1 * HASH_C1);
		m_s2 <= 32'(mix2 * HASH_C2);
	end

	assign home_valid = v_s2;
	assign home       = mix3[TABLE_BITS-1:0];

endmodule

// File: rtl/core/fohash_probe.sv
// slot memory and probe sequencer: clear, triangular probe walk, update
module fohash_probe import fohash_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  req_t               req,
	input  logic               home_valid,
	input  slot_idx_t          home,
	input  logic [LIMIT_W-1:0] load_limit,
	output logic               idle,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_RESULT
	} state_t;

	state_t             state_q;
	slot_idx_t          clr_q;
	logic [LIMIT_W-1:0] count_q;
	rsp_t               rsp_q;

	req_t      req_q;
	slot_idx_t pos_q, step_q, tries_q;

	slot_t     slot_mem [TABLE_SIZE];
	slot_t     rd_q;
	slot_idx_t rd_addr, wr_addr, pos_next;
	slot_t     wr_data;
	logic      wr_en;

	logic hit, empty, finish, set_ok;
	rsp_t res;

	assign pos_next = pos_q + step_q;
	assign rd_addr  = (state_q == ST_HASH) ? home : pos_next;

	assign hit    = rd_q.live && (rd_q.key == req_q.key);
	assign empty  = !rd_q.live;
	// probe ends on a match, a free slot, or once the whole table has been visited
	assign finish = hit || empty || (&tries_q);
	assign set_ok = (req_q.func == FUNC_SET) && (hit || (empty && (count_q < load_limit)));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = '{live: 1'b1, key: req_q.key, value: req_q.new_value};
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_PROBE: begin
				wr_en = finish && set_ok;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		res.key_present = hit;
		res.status      = STATUS_DONE;
		if (req_q.func == FUNC_GET) begin
			res.read_value = hit ? $signed(rd_q.value) : req_q.fallback;
		end else if (set_ok) begin
			res.read_value = req_q.new_value;
		end else begin
			res.read_value  = '0;
			res.key_present = 1'b0;
			res.status      = STATUS_FULL;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		rd_q <= slot_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			rsp_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (home_valid) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (finish) begin
						rsp_q   <= res;
						state_q <= ST_RESULT;
						if (set_ok && !hit) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_RESULT: begin
					if (rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= req;
		end
		if (state_q == ST_HASH && home_valid) begin
			pos_q   <= home;
			step_q  <= TABLE_BITS'(1);
			tries_q <= '0;
		end else if (state_q == ST_PROBE && !finish) begin
			pos_q   <= pos_next;
			step_q  <= step_q + 1'b1;
			tries_q <= tries_q + 1'b1;
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign rsp_valid = (state_q == ST_RESULT);
	assign rsp       = rsp_q;

endmodule

// File: rtl/core/flat_open_addressing_hash_table.sv
// a request passes the hash stages, then the probe walk, then the output register;
// a new request is taken only once the probe has handed on the previous response;
// the probe walk reads one slot per cycle from the single-port-read slot memory
// reset: asynchronous, clears control state and count, then a clearing pass over
// all TABLE_SIZE (1024) slots empties the slot memory before any request is taken
module flat_open_addressing_hash_table import fohash_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	fohash_req_if.sink         req,
	fohash_rsp_if.source       rsp,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	logic [LIMIT_W-1:0] load_limit_q;
	logic               start, idle;
	logic               home_valid;
	slot_idx_t          home;
	logic               prb_valid, prb_ready;
	rsp_t               prb_rsp;
	req_t               req_data;
	logic               out_full_q;
	rsp_t               out_q;

	assign req_data = '{func: req.func, key: req.key, new_value: req.new_value,
		fallback: req.fallback};
	assign req.ready = idle;
	assign start     = req.valid && idle;

	fohash_hash u_hash (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start),
		.key        (req.key),
		.home_valid (home_valid),
		.home       (home)
	);

	fohash_probe u_probe (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req_data),
		.home_valid (home_valid),
		.home       (home),
		.load_limit (load_limit_q),
		.idle       (idle),
		.rsp_valid  (prb_valid),
		.rsp_ready  (prb_ready),
		.rsp        (prb_rsp)
	);

	// output register frees the probe while a response transaction waits
	assign prb_ready = !out_full_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_limit_q <= LIMIT_RESET;
			out_full_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				load_limit_q <= cfg_wdata;
			end
			if (prb_ready) begin
				out_full_q <= prb_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prb_ready && prb_valid) begin
			out_q <= prb_rsp;
		end
	end

	assign rsp.valid       = out_full_q;
	assign rsp.read_value  = out_q.read_value;
	assign rsp.key_present = out_q.key_present;
	assign rsp.status      = out_q.status;

endmodule

// File: test/fohash_checker.sv
// response checker for the hash table: tracks the slot table and compares every response
`timescale 1ns / 100ps
module fohash_checker import fohash_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	fohash_req_if              req,
	fohash_rsp_if              rsp,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	output int                 errors,
	output int                 open_count
);

	logic                      live_map  [TABLE_SIZE];
	logic [KEY_W-1:0]          key_map   [TABLE_SIZE];
	logic signed [VALUE_W-1:0] value_map [TABLE_SIZE];
	logic [LIMIT_W-1:0]        live_count;
	logic [LIMIT_W-1:0]        limit_reg;
	rsp_t                      pending_rsp_q [$];

	// murmur3 32-bit finalizer, top bit dropped
	function automatic logic [30:0] home_of(input logic [KEY_W-1:0] k);
		logic [31:0] h;
		h = k;
		h = h ^ (h >> 16);
		h = h * HASH_C1;
		h = h ^ (h >> 13);
		h = h * HASH_C2;
		h = h ^ (h >> 16);
		return 31'(h & HASH_MASK31);
	endfunction

	function automatic rsp_t lookup_or_store(input req_t r);
		slot_idx_t pos;
		int        step;
		logic      found;
		logic      present;
		rsp_t      res;
		pos = slot_idx_t'(home_of(r.key));
		step = 1;
		found = 1'b0;
		// triangular walk: offsets 1, 2, 3 ... wrapping around the table
		for (int tries = 0; tries < TABLE_SIZE && !found; tries++) begin
			if (!live_map[pos] || key_map[pos] == r.key) begin
				found = 1'b1;
			end else begin
				pos = pos + slot_idx_t'(step);
				step++;
			end
		end
		present = found && live_map[pos];
		res.key_present = present;
		res.status = STATUS_DONE;
		if (r.func == FUNC_GET) begin
			res.read_value = present ? value_map[pos] : r.fallback;
		end else if (present) begin
			value_map[pos] = r.new_value;
			res.read_value = r.new_value;
		end else if (!found || live_count >= limit_reg) begin
			res.read_value = '0;
			res.status = STATUS_FULL;
		end else begin
			live_map[pos] = 1'b1;
			key_map[pos] = r.key;
			value_map[pos] = r.new_value;
			live_count++;
			res.read_value = r.new_value;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		rsp_t want;
		req_t seen_req;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++) live_map[i] = 1'b0;
			live_count = '0;
			limit_reg = LIMIT_RESET;
			pending_rsp_q.delete();
			errors = 0;
			open_count <= 0;
		end else begin
			if (cfg_we) limit_reg = cfg_wdata;
			// pop before push so a same-edge request never matches its own response
			if (rsp.valid && rsp.ready) begin
				if (pending_rsp_q.size() == 0) begin
					errors++;
					$error("unexpected response transaction: read_value %0d", rsp.read_value);
				end else begin
					want = pending_rsp_q.pop_front();
					if (rsp.read_value !== want.read_value) begin
						errors++;
						$error("read_value expected %0d actual %0d",
							want.read_value, rsp.read_value);
					end
					if (rsp.key_present !== want.key_present) begin
						errors++;
						$error("key_present expected %0b actual %0b",
							want.key_present, rsp.key_present);
					end
					if (rsp.status !== want.status) begin
						errors++;
						$error("status expected %0b actual %0b", want.status, rsp.status);
					end
				end
			end
			if (req.valid && req.ready) begin
				seen_req.func = req.func;
				seen_req.key = req.key;
				seen_req.new_value = req.new_value;
				seen_req.fallback = req.fallback;
				pending_rsp_q.push_back(lookup_or_store(seen_req));
			end
			open_count <= pending_rsp_q.size();
		end
	end

endmodule

// File: test/tb_top.sv
// top of the hash table testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
	import fohash_pkg::*;

	localparam int POOL_SIZE      = 1300;
	localparam int WATCHDOG_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;
	int                 errors;
	int                 open_count;
	int                 stalled;
	int                 sets_sent;
	int                 gets_sent;
	int                 limit_writes;
	int                 next_new;
	logic               calm;
	logic [KEY_W-1:0]   key_pool [POOL_SIZE];

	fohash_req_if req_ch ();
	fohash_rsp_if rsp_ch ();

	flat_open_addressing_hash_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	fohash_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.errors     (errors),
		.open_count (open_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly short gaps, a few long ones; none while calm
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_req(input logic f, input logic [KEY_W-1:0] k,
			input logic [31:0] nv, input logic [31:0] fb);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.key <= k;
		req_ch.new_value <= nv;
		req_ch.fallback <= fb;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (f == FUNC_SET) sets_sent++;
		else gets_sent++;
		if ((sets_sent + gets_sent) % 64 == 0) calm = ($urandom_range(0, 3) == 0);
	endtask

	// new_pct: percentage of requests that are sets of a fresh key from the pool
	task automatic send_random(input int new_pct);
		int         r;
		logic       f;
		logic [31:0] k;
		r = $urandom_range(0, 99);
		if (r < new_pct && next_new < POOL_SIZE) begin
			f = FUNC_SET;
			k = key_pool[next_new];
			next_new++;
		end else if (r < 90 && next_new > 0) begin
			f = 1'($urandom_range(0, 1));
			k = key_pool[$urandom_range(0, next_new - 1)];
		end else begin
			f = 1'($urandom_range(0, 1));
			k = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 15)) : $urandom();
		end
		send_req(f, k, pick_word(), pick_word());
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (open_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_writes++;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.func <= FUNC_GET;
		req_ch.key <= '0;
		req_ch.new_value <= '0;
		req_ch.fallback <= '0;
		sets_sent = 0;
		gets_sent = 0;
		limit_writes = 0;
		next_new = 0;
		calm = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_limit(LIMIT_W'(512));
		send_req(FUNC_GET, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
		send_req(FUNC_SET, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
		send_req(FUNC_GET, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
		send_req(FUNC_SET, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		send_req(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		send_req(FUNC_SET, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
		send_req(FUNC_GET, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
		send_req(FUNC_SET, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
		send_req(FUNC_SET, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000);
		send_req(FUNC_GET, 32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFF);
		send_req(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
		send_req(FUNC_SET, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		send_req(FUNC_SET, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
		send_req(FUNC_GET, 32'h1234_5678, 32'hAAAA_AAAA, 32'h5555_5555);
		drain();

		// limit below the live count: only updates of present keys go through
		write_limit(LIMIT_W'(3));
		send_req(FUNC_SET, 32'hDEAD_BEEF, 32'h0000_0042, 32'h0000_0000);
		send_req(FUNC_SET, 32'hAAAA_AAAA, 32'h8000_0001, 32'h0000_0000);
		send_req(FUNC_GET, 32'hDEAD_BEEF, 32'h0000_0000, 32'h7FFF_FFFE);
		send_req(FUNC_GET, 32'hAAAA_AAAA, 32'h0000_0000, 32'h0000_0000);
		drain();

		// limit equal to the count, then one above it
		write_limit(LIMIT_W'(6));
		send_req(FUNC_SET, 32'hC0FF_EE00, 32'h0000_0007, 32'h0000_0000);
		drain();
		write_limit(LIMIT_W'(7));
		send_req(FUNC_SET, 32'hC0FF_EE00, 32'h0000_0008, 32'h0000_0000);
		send_req(FUNC_SET, 32'h0BAD_F00D, 32'h0000_0009, 32'h0000_0000);
		send_req(FUNC_GET, 32'hC0FF_EE00, 32'h0000_0000, 32'hFFFF_FFFF);
		drain();

		write_limit('0);
		repeat (100) send_random(40);
		drain();

		// fill toward the largest limit so probe walks get long and the limit is hit
		write_limit(LIMIT_W'(1023));
		repeat (1250) send_random(75);
		drain();

		write_limit(LIMIT_W'(1));
		repeat (60) send_random(30);
		drain();

		$display("covered %0d requests (%0d sets, %0d gets) over %0d load limit writes",
			sets_sent + gets_sent, sets_sent, gets_sent, limit_writes);
		$display("load limits 512, 3, 6, 7, 0, 1023 and 1; %0d checker errors", errors);
		if (errors == 0 && open_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// response side: ready runs of random length with stalls between them
	initial begin : rsp_ready_gen
		int gap;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			rsp_ch.ready <= 1'b1;
			if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 200)) @(posedge clk);
			else repeat ($urandom_range(1, 8)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stalled <= 0;
		end else begin
			stalled <= stalled + 1;
			if (stalled == WATCHDOG_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

endmodule
